[rtl/mbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg - shared definitions for the Morse bit packer
// Word geometry, character codes, the letter table and the queue entry type.
// ----------------------------------------------------------------------------
package mbp_pkg;

	// packing word geometry
	localparam int WORD_BITS = 32;
	localparam int FILL_W    = $clog2(WORD_BITS);
	localparam int SH_W      = $clog2(2 * WORD_BITS + 1);
	localparam int OUT_W     = 32;
	localparam int USED_W    = 6;

	// longest append: thirteen pattern bits and one gap bit
	localparam int APP_W     = 14;
	localparam int LEN_W     = 4;
	localparam int IDX_W     = 5;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_END   = 8'h5B;
	localparam logic [LEN_W-1:0] SPACE_BITS = LEN_W'(7);

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// results of one character: a full word and/or a flushed partial word
	typedef struct packed {
		logic                  full_v;
		logic [WORD_BITS-1:0]  full_word;
		logic                  full_fin;
		logic                  part_v;
		logic [WORD_BITS-1:0]  part_word;
		logic [USED_W-1:0]     part_used;
	} entry_t;

	// queue head towards the back end
	typedef struct packed {
		logic   empty;
		entry_t head;
	} q_head_t;

	// Morse on/off pattern of a letter, dot = 1, dash = 111
	function automatic logic [APP_W-2:0] morse_pattern(input logic [IDX_W-1:0] idx);
		logic [APP_W-2:0] c;
		unique case (idx)
			5'd0:    c = 13'h17;
			5'd1:    c = 13'h1D5;
			5'd2:    c = 13'h75D;
			5'd3:    c = 13'h75;
			5'd4:    c = 13'h01;
			5'd5:    c = 13'h15D;
			5'd6:    c = 13'h1DD;
			5'd7:    c = 13'h55;
			5'd8:    c = 13'h5;
			5'd9:    c = 13'h1777;
			5'd10:   c = 13'h1D7;
			5'd11:   c = 13'h175;
			5'd12:   c = 13'h77;
			5'd13:   c = 13'h1D;
			5'd14:   c = 13'h777;
			5'd15:   c = 13'h5DD;
			5'd16:   c = 13'h1DD7;
			5'd17:   c = 13'h5D;
			5'd18:   c = 13'h15;
			5'd19:   c = 13'h7;
			5'd20:   c = 13'h57;
			5'd21:   c = 13'h157;
			5'd22:   c = 13'h177;
			5'd23:   c = 13'h757;
			5'd24:   c = 13'h1D77;
			5'd25:   c = 13'h775;
			default: c = '0;
		endcase
		return c;
	endfunction

	// pattern length in bits
	function automatic logic [LEN_W-1:0] letter_len(input logic [IDX_W-1:0] idx);
		logic [LEN_W-1:0] l;
		unique case (idx)
			5'd0, 5'd13, 5'd18:                         l = 4'd5;
			5'd1, 5'd5, 5'd6, 5'd10, 5'd11, 5'd21, 5'd22: l = 4'd9;
			5'd2, 5'd14, 5'd15, 5'd23, 5'd25:           l = 4'd11;
			5'd3, 5'd7, 5'd12, 5'd17, 5'd20:            l = 4'd7;
			5'd4:                                       l = 4'd1;
			5'd8, 5'd19:                                l = 4'd3;
			5'd9, 5'd16, 5'd24:                         l = 4'd13;
			default:                                    l = 4'd0;
		endcase
		return l;
	endfunction

	// word as seen on the 32-bit result port
	function automatic logic [OUT_W-1:0] to_out(input logic [WORD_BITS-1:0] w);
		logic [63:0] wide;
		wide = 64'(w);
		return wide[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/mbp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_front - character classifier and bit packer
// Classifies each character, looks up its pattern, merges it into the
// accumulator and queues the full and flushed words that it produces.
// ----------------------------------------------------------------------------
module mbp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [7:0]           character,
	input  wire logic                 last_char,
	output logic                      enq,
	output mbp_pkg::entry_t           enq_entry
);

	typedef enum logic [1:0] {
		CLS_SPACE,
		CLS_LETTER,
		CLS_OTHER
	} cls_t;

	localparam int W2 = 2 * mbp_pkg::WORD_BITS;

	logic [mbp_pkg::WORD_BITS-1:0] acc_q;
	logic [mbp_pkg::FILL_W-1:0]    fill_q;

	cls_t                          cls;
	logic [mbp_pkg::IDX_W-1:0]     idx;
	logic [mbp_pkg::APP_W-1:0]     app_v;
	logic [mbp_pkg::LEN_W-1:0]     app_n;
	logic [mbp_pkg::SH_W-1:0]      sum;
	logic [mbp_pkg::SH_W-1:0]      sh;
	logic [W2-1:0]                 merged;
	logic                          full_hit;
	logic                          flush;
	logic [mbp_pkg::WORD_BITS-1:0] acc_nx;
	logic [mbp_pkg::FILL_W-1:0]    fill_nx;
	logic [7:0]                    ofs;

	// classify the character
	always_comb begin
		ofs = character - mbp_pkg::CH_A;
		idx = ofs[mbp_pkg::IDX_W-1:0];
		priority if (character == mbp_pkg::CH_SPACE) begin
			cls = CLS_SPACE;
		end else if (character >= mbp_pkg::CH_A && character < mbp_pkg::CH_END) begin
			cls = CLS_LETTER;
		end else begin
			cls = CLS_OTHER;
		end
	end

	// bits to append: pattern with a trailing gap, or the word gap
	always_comb begin
		unique case (cls)
			CLS_LETTER: begin
				app_v = {mbp_pkg::morse_pattern(idx), 1'b0};
				app_n = mbp_pkg::letter_len(idx) + mbp_pkg::LEN_W'(1);
			end
			CLS_SPACE: begin
				app_v = '0;
				app_n = mbp_pkg::SPACE_BITS;
			end
			default: begin
				app_v = '0;
				app_n = '0;
			end
		endcase
	end

	// merge below the filled bits in a double-width window
	always_comb begin
		sum      = mbp_pkg::SH_W'(fill_q) + mbp_pkg::SH_W'(app_n);
		sh       = mbp_pkg::SH_W'(W2) - sum;
		merged   = {acc_q, {mbp_pkg::WORD_BITS{1'b0}}} | (W2'(app_v) << sh);
		full_hit = sum >= mbp_pkg::SH_W'(mbp_pkg::WORD_BITS);
		flush    = last_char || (cls == CLS_OTHER);
		if (full_hit) begin
			acc_nx  = merged[mbp_pkg::WORD_BITS-1:0];
			fill_nx = mbp_pkg::FILL_W'(sum - mbp_pkg::SH_W'(mbp_pkg::WORD_BITS));
		end else begin
			acc_nx  = merged[W2-1:mbp_pkg::WORD_BITS];
			fill_nx = mbp_pkg::FILL_W'(sum);
		end
	end

	// build the queue entry
	always_comb begin
		enq_entry.full_v    = full_hit;
		enq_entry.full_word = merged[W2-1:mbp_pkg::WORD_BITS];
		enq_entry.full_fin  = flush && (fill_nx == '0);
		enq_entry.part_v    = flush && (fill_nx != '0);
		enq_entry.part_word = acc_nx;
		enq_entry.part_used = mbp_pkg::USED_W'(fill_nx);
		enq = accept && (enq_entry.full_v || enq_entry.part_v);
	end

	// advance the packer, clear it on flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (flush) begin
				acc_q  <= '0;
				fill_q <= '0;
			end else begin
				acc_q  <= acc_nx;
				fill_q <= fill_nx;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/mbp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_queue - entry queue between packer and output sequencer
// Holds the word groups of a few characters so either side may stall.
// ----------------------------------------------------------------------------
module mbp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             enq,
	input  wire mbp_pkg::entry_t  enq_entry,
	input  wire logic             deq,
	output logic                  q_full,
	output mbp_pkg::q_head_t      q_head
);

	mbp_pkg::entry_t              mem_q [mbp_pkg::Q_DEPTH];
	logic [mbp_pkg::Q_PTR_W-1:0]  wr_q;
	logic [mbp_pkg::Q_PTR_W-1:0]  rd_q;
	logic [mbp_pkg::Q_CNT_W-1:0]  cnt_q;

	function automatic logic [mbp_pkg::Q_PTR_W-1:0] ptr_inc(
		input logic [mbp_pkg::Q_PTR_W-1:0] p);
		logic [mbp_pkg::Q_PTR_W-1:0] r;
		if (p == mbp_pkg::Q_PTR_W'(mbp_pkg::Q_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + mbp_pkg::Q_PTR_W'(1);
		end
		return r;
	endfunction

	assign q_full       = cnt_q == mbp_pkg::Q_CNT_W'(mbp_pkg::Q_DEPTH);
	assign q_head.empty = cnt_q == '0;
	assign q_head.head  = mem_q[rd_q];

	// store incoming entries
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_q] <= enq_entry;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (deq) begin
				rd_q <= ptr_inc(rd_q);
			end
			unique case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + mbp_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - mbp_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mbp_pkg::Q_CNT_W'(mbp_pkg::Q_DEPTH))
		else $error("queue occupancy beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !enq)
		else $error("entry written into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_head.empty |-> !deq)
		else $error("entry taken from an empty queue");

	a_entry_useful: assert property (@(posedge clk) disable iff (!arst_n)
		enq |-> (enq_entry.full_v || enq_entry.part_v))
		else $error("queued entry carries no word");

endmodule
`default_nettype wire

[rtl/mbp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_back - output sequencer
// Presents the words of the head entry one at a time, full word first.
// ----------------------------------------------------------------------------
module mbp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mbp_pkg::q_head_t q_head,
	input  wire logic             pop,
	output logic                  deq,
	output logic                  empty,
	output logic [31:0]           packed_word,
	output logic [5:0]            bits_used,
	output logic                  final_word
);

	logic sel_q;
	logic cur_full;
	logic take;

	assign empty    = q_head.empty;
	assign cur_full = q_head.head.full_v && !sel_q;
	assign take     = pop && !q_head.empty;
	assign deq      = take && !(cur_full && q_head.head.part_v);

	// select the word on the result ports
	always_comb begin
		if (cur_full) begin
			packed_word = mbp_pkg::to_out(q_head.head.full_word);
			bits_used   = mbp_pkg::USED_W'(mbp_pkg::WORD_BITS);
			final_word  = q_head.head.full_fin;
		end else begin
			packed_word = mbp_pkg::to_out(q_head.head.part_word);
			bits_used   = q_head.head.part_used;
			final_word  = 1'b1;
		end
	end

	// step to the flushed word, or drop the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !deq;
		end
	end

	a_sel_has_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (!q_head.empty && q_head.head.full_v && q_head.head.part_v))
		else $error("second word selected without a pair in the head entry");

	a_sel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_q && take) |=> !sel_q)
		else $error("flushed word not dropped after delivery");

endmodule
`default_nettype wire

[rtl/morse_bit_packer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_bit_packer - Morse encoder packing on/off bits into 32-bit words
// Letters, spaces and end-of-message characters in; packed words out.
// ----------------------------------------------------------------------------
// One character is taken per clock while full is low. Each character yields
// zero, one or two words; words leave at one per clock through pop, so a
// character that both completes a word and flushes the remainder hands its
// two words to the result side through separate pops. The packer merges a
// character with a table lookup plus one double-width shift; a four-entry
// queue of per-character word groups sits between packer and result ports,
// and full rises only when that queue holds four groups not yet delivered.
// Each word is registered in the queue and presented from its head.
// ----------------------------------------------------------------------------
module morse_bit_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  character,
	input  wire logic        last_char,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      packed_word,
	output logic [5:0]       bits_used,
	output logic             final_word
);

	logic              accept;
	logic              enq;
	mbp_pkg::entry_t   enq_entry;
	logic              deq;
	mbp_pkg::q_head_t  q_head;

	assign accept = push && !full;

	mbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.character (character),
		.last_char (last_char),
		.enq       (enq),
		.enq_entry (enq_entry)
	);

	mbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_entry (enq_entry),
		.deq       (deq),
		.q_full    (full),
		.q_head    (q_head)
	);

	mbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (q_head),
		.pop         (pop),
		.deq         (deq),
		.empty       (empty),
		.packed_word (packed_word),
		.bits_used   (bits_used),
		.final_word  (final_word)
	);

endmodule
`default_nettype wire
